@@ rtl/idsu_pkg.sv @@
`default_nettype none
package idsu_pkg;

  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 16;
  localparam int QUANT_W    = 25;
  localparam int INDEX_W    = 4;
  localparam int STAT_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 48;
  localparam int FRAC_BITS  = 24;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_END    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PCT    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REPORT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [INDEX_W-1:0] REP_LAST = 4'd14;

  typedef struct packed {
    logic latch;
    logic clr_stats;
    logic clr_step;
    logic smp_rd;
    logic smp_wr;
    logic mul_start;
    logic mul_step;
    logic img_end;
    logic pct_zero;
    logic rank_mul;
    logic rank_fin;
    logic walk_step;
    logic push_pct;
    logic rep_start;
    logic push_rep;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mul_last;
    logic walk_found;
    logic out_free;
    logic n_zero;
    logic cur_zero;
    logic rep_last;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/idsu_if.sv @@
`default_nettype none
interface idsu_in_if;
  import idsu_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  candidate_value;
  logic [VALUE_W-1:0]  reference_value;
  logic [QUANT_W-1:0]  quantile_fraction;
  modport source (output valid, opcode, candidate_value, reference_value,
                  quantile_fraction, input ready);
  modport sink (input valid, opcode, candidate_value, reference_value,
                quantile_fraction, output ready);
endinterface

interface idsu_out_if;
  import idsu_pkg::*;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [INDEX_W-1:0] stat_index;
  logic [STAT_W-1:0]  stat_value;
  logic               last;
  modport source (output valid, result_kind, stat_index, stat_value, last,
                  input ready);
  modport sink (input valid, result_kind, stat_index, stat_value, last,
                output ready);
endinterface
`default_nettype wire

@@ rtl/idsu_ctrl.sv @@
`default_nettype none
module idsu_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [idsu_pkg::OPCODE_W-1:0] in_opcode,
  output logic                         in_ready,
  input  wire idsu_pkg::sts_t          sts,
  output idsu_pkg::cmd_t               cmd
);
  import idsu_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_SRD  = 4'd2;
  localparam logic [3:0] ST_SWR  = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_CMP  = 4'd5;
  localparam logic [3:0] ST_RMUL = 4'd6;
  localparam logic [3:0] ST_RFIN = 4'd7;
  localparam logic [3:0] ST_WALK = 4'd8;
  localparam logic [3:0] ST_PANS = 4'd9;
  localparam logic [3:0] ST_REP  = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_opcode)
            OP_SAMPLE: state_nxt = ST_SRD;
            OP_END: begin
              if (!sts.cur_zero) begin
                cmd.mul_start = 1'b1;
                state_nxt = ST_MUL;
              end
            end
            OP_PCT: begin
              if (sts.n_zero) begin
                cmd.pct_zero = 1'b1;
                state_nxt = ST_PANS;
              end else begin
                state_nxt = ST_RMUL;
              end
            end
            OP_REPORT: begin
              cmd.rep_start = 1'b1;
              state_nxt = ST_REP;
            end
            OP_CLEAR: begin
              cmd.clr_stats = 1'b1;
              state_nxt = ST_CLR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_SRD: begin
        cmd.smp_rd = 1'b1;
        state_nxt = ST_SWR;
      end
      ST_SWR: begin
        cmd.smp_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.img_end = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RMUL: begin
        cmd.rank_mul = 1'b1;
        state_nxt = ST_RFIN;
      end
      ST_RFIN: begin
        cmd.rank_fin = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_found) state_nxt = ST_PANS;
        else cmd.walk_step = 1'b1;
      end
      ST_PANS: begin
        if (sts.out_free) begin
          cmd.push_pct = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REP: begin
        if (sts.out_free) begin
          cmd.push_rep = 1'b1;
          if (sts.rep_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else state_r <= state_nxt;
  end

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> (state_r == ST_CLR)) else $error("no clear pass after reset");
  a_cmp_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.img_end |-> $past(cmd.mul_step && sts.mul_last))
    else $error("image compare without finished products");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.smp_rd |=> cmd.smp_wr) else $error("histogram update lost");
endmodule
`default_nettype wire

@@ rtl/idsu_datapath.sv @@
`default_nettype none
module idsu_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire idsu_pkg::cmd_t                cmd,
  output idsu_pkg::sts_t                     sts,
  input  wire logic [idsu_pkg::VALUE_W-1:0]  in_candidate,
  input  wire logic [idsu_pkg::VALUE_W-1:0]  in_reference,
  input  wire logic [idsu_pkg::QUANT_W-1:0]  in_quantile,
  input  wire logic                          cfg_wen,
  input  wire logic [idsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [idsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic [idsu_pkg::INDEX_W-1:0]       out_index,
  output logic [idsu_pkg::STAT_W-1:0]        out_value,
  output logic                               out_last
);
  import idsu_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int DEPTH = 1 << SB;
  localparam int MW    = SUM_W + CB;
  localparam int MCW   = $clog2(CB);
  localparam int PW    = QUANT_W + CB;
  localparam int RW    = PW - FRAC_BITS + 1;
  localparam int CUMW  = CB + SB;
  localparam int CMPW  = (RW > CUMW) ? RW : CUMW;
  localparam logic [CB-1:0]    CMAX  = {CB{1'b1}};
  localparam logic [SUM_W-1:0] SMAX  = {SUM_W{1'b1}};
  localparam logic [SB-1:0]    DMAX  = {SB{1'b1}};
  localparam logic [PW-1:0]    ROUND = PW'((64'd1 << FRAC_BITS) - 64'd1);

  // configuration
  logic [2:0]  chan_cfg_r;
  logic [15:0] width_cfg_r, thr_cfg_r;
  logic [2:0]  cc_w;
  logic [15:0] w_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg_r  <= 3'd1;
      width_cfg_r <= 16'd1;
      thr_cfg_r   <= 16'd6;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_CHANNELS:  chan_cfg_r  <= cfg_wdata[2:0];
        REG_WIDTH:     width_cfg_r <= cfg_wdata;
        REG_THRESHOLD: thr_cfg_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cc_w = (chan_cfg_r == 3'd0) ? 3'd1 : ((chan_cfg_r > 3'd4) ? 3'd4 : chan_cfg_r);
  assign w_w  = (width_cfg_r == 16'd0) ? 16'd1 : width_cfg_r;

  // input capture
  logic [SB-1:0]      cand_r, ref_r;
  logic [QUANT_W-1:0] q_r;
  logic [SB-1:0]      d_w;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cand_r <= in_candidate[SB-1:0];
      ref_r  <= in_reference[SB-1:0];
      q_r    <= in_quantile;
    end
  end

  assign d_w = (cand_r > ref_r) ? cand_r - ref_r : ref_r - cand_r;

  // histogram memory
  logic [CB-1:0] hist_mem [DEPTH];
  logic [CB-1:0] rdata_r;
  logic [SB-1:0] raddr_w, waddr_w, clr_addr_r, walk_addr_r;
  logic [CB-1:0] wdata_w;
  logic          wen_w;

  assign raddr_w = cmd.smp_rd ? d_w : walk_addr_r;
  assign wen_w   = cmd.clr_step || cmd.smp_wr;
  assign waddr_w = cmd.clr_step ? clr_addr_r : d_w;
  assign wdata_w = cmd.clr_step ? '0 : ((rdata_r == CMAX) ? CMAX : rdata_r + 1'b1);

  always_ff @(posedge clk) begin
    if (wen_w) hist_mem[waddr_w] <= wdata_w;
    rdata_r <= hist_mem[raddr_w];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_stats) clr_addr_r <= '0;
    else if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
  end

  // statistics
  logic [SUM_W-1:0] tsum_r, cur_sum_r, worst_sum_r;
  logic [63:0]      sq_sum_r;
  logic [2*SB-1:0]  sq_r;
  logic [CB-1:0]    exc_r, n_r, img_r, wsi_r, wimg_r, wn_r, cur_n_r;
  logic [SB-1:0]    wd_r;
  logic [15:0]      wx_r, wy_r, px_r, py_r;
  logic [1:0]       wch_r, pch_r;
  logic [31:0]      wpair_r;
  logic [SUM_W:0]   tsum_add_w, cur_add_w;
  logic [64:0]      sq_add_w;
  logic             ch_wrap_w, x_wrap_w;
  logic             worse_img_w;

  assign tsum_add_w = {1'b0, tsum_r} + (SUM_W+1)'(d_w);
  assign cur_add_w  = {1'b0, cur_sum_r} + (SUM_W+1)'(d_w);
  assign sq_add_w   = {1'b0, sq_sum_r} + 65'(sq_r);
  assign ch_wrap_w  = (3'({1'b0, pch_r}) + 3'd1) >= cc_w;
  assign x_wrap_w   = ({1'b0, px_r} + 17'd1) >= {1'b0, w_w};

  always_ff @(posedge clk) begin
    if (cmd.smp_rd) sq_r <= d_w * d_w;
  end

  // shift-and-add multipliers for the image mean compare
  logic [MW-1:0]  mc_a_r, mc_b_r, acc_a_r, acc_b_r;
  logic [CB-1:0]  mp_a_r, mp_b_r;
  logic [MCW-1:0] mcnt_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mc_a_r  <= MW'(cur_sum_r);
      mp_a_r  <= wn_r;
      mc_b_r  <= MW'(worst_sum_r);
      mp_b_r  <= cur_n_r;
      acc_a_r <= '0;
      acc_b_r <= '0;
      mcnt_r  <= '0;
    end else if (cmd.mul_step) begin
      if (mp_a_r[0]) acc_a_r <= acc_a_r + mc_a_r;
      if (mp_b_r[0]) acc_b_r <= acc_b_r + mc_b_r;
      mc_a_r <= mc_a_r << 1;
      mc_b_r <= mc_b_r << 1;
      mp_a_r <= mp_a_r >> 1;
      mp_b_r <= mp_b_r >> 1;
      mcnt_r <= mcnt_r + 1'b1;
    end
  end

  assign worse_img_w = acc_a_r > acc_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_stats) begin
      tsum_r <= '0; cur_sum_r <= '0; worst_sum_r <= '0; sq_sum_r <= '0;
      exc_r <= '0; n_r <= '0; img_r <= '0; wsi_r <= '0; wimg_r <= '0;
      wn_r <= CB'(1); cur_n_r <= '0; wd_r <= '0; wx_r <= '0; wy_r <= '0;
      wch_r <= '0; wpair_r <= '0; px_r <= '0; py_r <= '0; pch_r <= '0;
    end else if (cmd.smp_wr) begin
      tsum_r    <= tsum_add_w[SUM_W] ? SMAX : tsum_add_w[SUM_W-1:0];
      cur_sum_r <= cur_add_w[SUM_W] ? SMAX : cur_add_w[SUM_W-1:0];
      sq_sum_r  <= sq_add_w[64] ? {64{1'b1}} : sq_add_w[63:0];
      if (16'(d_w) > thr_cfg_r && exc_r != CMAX) exc_r <= exc_r + 1'b1;
      if (n_r != CMAX) n_r <= n_r + 1'b1;
      if (cur_n_r != CMAX) cur_n_r <= cur_n_r + 1'b1;
      if (d_w > wd_r) begin
        wd_r    <= d_w;
        wsi_r   <= img_r;
        wx_r    <= px_r;
        wy_r    <= py_r;
        wch_r   <= pch_r;
        wpair_r <= {16'(cand_r), 16'(ref_r)};
      end
      if (ch_wrap_w) begin
        pch_r <= '0;
        if (x_wrap_w) begin
          px_r <= '0;
          if (py_r != 16'hFFFF) py_r <= py_r + 1'b1;
        end else begin
          px_r <= px_r + 1'b1;
        end
      end else begin
        pch_r <= pch_r + 1'b1;
      end
    end else if (cmd.img_end) begin
      if (worse_img_w) begin
        worst_sum_r <= cur_sum_r;
        wn_r        <= cur_n_r;
        wimg_r      <= img_r;
      end
      if (img_r != CMAX) img_r <= img_r + 1'b1;
      cur_sum_r <= '0;
      cur_n_r   <= '0;
      px_r <= '0; py_r <= '0; pch_r <= '0;
    end
  end

  // percentile walk
  logic [PW-1:0]   prod_r;
  logic [RW-1:0]   rank_r;
  logic [CUMW-1:0] cum_r, cum_nxt;
  logic [SB-1:0]   pend_idx_r, pct_r;
  logic            pend_r, found_r;

  assign cum_nxt = cum_r + CUMW'(rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.rank_mul) prod_r <= q_r * n_r;
    if (cmd.rank_fin) rank_r <= RW'((prod_r + ROUND) >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (cmd.rank_fin) begin
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      walk_addr_r <= '0;
      cum_r       <= '0;
    end else if (cmd.walk_step) begin
      walk_addr_r <= walk_addr_r + 1'b1;
      pend_idx_r  <= walk_addr_r;
      pend_r      <= 1'b1;
      if (pend_r) begin
        cum_r <= cum_nxt;
        if (CMPW'(cum_nxt) >= CMPW'(rank_r)) begin
          found_r <= 1'b1;
          pct_r   <= pend_idx_r;
        end else if (pend_idx_r == DMAX) begin
          found_r <= 1'b1;
          pct_r   <= DMAX;
        end
      end
    end else if (cmd.pct_zero) begin
      pct_r <= '0;
    end
  end

  // report index and result register
  logic [INDEX_W-1:0] rep_idx_r;
  logic [63:0]        rep_val_w;

  always_ff @(posedge clk) begin
    if (cmd.rep_start) rep_idx_r <= '0;
    else if (cmd.push_rep) rep_idx_r <= rep_idx_r + 1'b1;
  end

  always_comb begin
    case (rep_idx_r)
      4'd0:    rep_val_w = 64'(img_r);
      4'd1:    rep_val_w = 64'(n_r);
      4'd2:    rep_val_w = 64'(tsum_r);
      4'd3:    rep_val_w = sq_sum_r;
      4'd4:    rep_val_w = 64'(exc_r);
      4'd5:    rep_val_w = 64'(wd_r);
      4'd6:    rep_val_w = 64'(wsi_r);
      4'd7:    rep_val_w = 64'(wx_r);
      4'd8:    rep_val_w = 64'(wy_r);
      4'd9:    rep_val_w = 64'(wch_r);
      4'd10:   rep_val_w = 64'(wpair_r);
      4'd11:   rep_val_w = 64'(wimg_r);
      4'd12:   rep_val_w = 64'(worst_sum_r);
      4'd13:   rep_val_w = 64'(wn_r);
      4'd14:   rep_val_w = 64'(cur_n_r);
      default: rep_val_w = '0;
    endcase
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.push_pct || cmd.push_rep) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pct) begin
      out_kind  <= 1'b0;
      out_index <= '0;
      out_value <= 64'(pct_r);
      out_last  <= 1'b1;
    end else if (cmd.push_rep) begin
      out_kind  <= 1'b1;
      out_index <= rep_idx_r;
      out_value <= rep_val_w;
      out_last  <= (rep_idx_r == REP_LAST);
    end
  end

  assign out_valid = out_valid_r;

  assign sts.clr_last   = (clr_addr_r == DMAX);
  assign sts.mul_last   = (mcnt_r == MCW'(CB-1));
  assign sts.walk_found = found_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.n_zero     = (n_r == '0);
  assign sts.cur_zero   = (cur_n_r == '0);
  assign sts.rep_last   = (rep_idx_r == REP_LAST);

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_pct || cmd.push_rep) |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && cmd.smp_wr)) else $error("two histogram writers");
  a_worst_src: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(wd_r) |-> $past(cmd.smp_wr || cmd.clr_stats || !rst_n))
    else $error("worst difference changed without a sample");
endmodule
`default_nettype wire

@@ rtl/image_difference_statistics_unit.sv @@
// sample pair: read the bin, then update bin and sums, before the next accept
// end of image: bit-serial cross-multiply pair, then the compare (skipped if the image is empty)
// percentile: rank multiply, then a walk of one histogram bin per cycle
// report: 15 result beats, one per cycle while the sink is ready
// reset and clear: a pass over every bin zeroes the histogram, input held off
`default_nettype none
module image_difference_statistics_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  idsu_in_if.sink                              in_s,
  idsu_out_if.source                           out_s,
  input  wire logic                            cfg_wen,
  input  wire logic [idsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [idsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import idsu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  idsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_opcode (in_s.opcode),
    .in_ready  (in_s.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  idsu_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_candidate (in_s.candidate_value),
    .in_reference (in_s.reference_value),
    .in_quantile  (in_s.quantile_fraction),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_s.ready),
    .out_valid    (out_s.valid),
    .out_kind     (out_s.result_kind),
    .out_index    (out_s.stat_index),
    .out_value    (out_s.stat_value),
    .out_last     (out_s.last)
  );
endmodule
`default_nettype wire
